@@ hdl/stc_pkg.sv @@
`timescale 1ns / 1ps
package stc_pkg;

	localparam int FIFO_DEPTH_DEF = 256;
	localparam logic [7:0] NAV_CODE_BASE = 8'd128;

	localparam logic [7:0] SC_PREFIX   = 8'hE0;
	localparam logic [6:0] SC_LSHIFT   = 7'h2A;
	localparam logic [6:0] SC_RSHIFT   = 7'h36;
	localparam logic [6:0] SC_CTRL     = 7'h1D;
	localparam logic [6:0] SC_UP       = 7'h48;
	localparam logic [6:0] SC_DOWN     = 7'h50;
	localparam logic [6:0] SC_LEFT     = 7'h4B;
	localparam logic [6:0] SC_RIGHT    = 7'h4D;
	localparam logic [6:0] SC_PGUP     = 7'h49;
	localparam logic [6:0] SC_PGDN     = 7'h51;
	localparam logic [6:0] SC_HOME     = 7'h47;
	localparam logic [6:0] SC_END      = 7'h4F;

	localparam int MAP_LEN = 59;

	localparam logic [7:0] PLAIN_MAP [MAP_LEN] = '{
		8'd0,  8'd27, "1",  "2",  "3",  "4",  "5",  "6",  "7",  "8",  "9",  "0",
		"-",   "=",   8'd8, 8'd9, "q",  "w",  "e",  "r",  "t",  "y",  "u",  "i",
		"o",   "p",   "[",  "]",  8'd10, 8'd0, "a", "s",  "d",  "f",  "g",  "h",
		"j",   "k",   "l",  ";",  8'd39, 8'd96, 8'd0, 8'd92, "z", "x", "c", "v",
		"b",   "n",   "m",  ",",  ".",  "/",  8'd0, "*",  8'd0, " ",  8'd0
	};

	localparam logic [7:0] SHIFT_MAP [MAP_LEN] = '{
		8'd0,  8'd27, "!",  "@",  "#",  "$",  "%",  "^",  "&",  "*",  "(",  ")",
		"_",   "+",   8'd8, 8'd9, "Q",  "W",  "E",  "R",  "T",  "Y",  "U",  "I",
		"O",   "P",   "{",  "}",  8'd10, 8'd0, "A", "S",  "D",  "F",  "G",  "H",
		"J",   "K",   "L",  ":",  8'd34, 8'd126, 8'd0, 8'd124, "Z", "X", "C", "V",
		"B",   "N",   "M",  "<",  ">",  "?",  8'd0, "*",  8'd0, " ",  8'd0
	};

	function automatic logic [7:0] map_char(input logic [6:0] code, input logic shifted);
		logic [7:0] c;
		c = 8'd0;
		if (int'(code) < MAP_LEN) begin
			c = shifted ? SHIFT_MAP[code[5:0]] : PLAIN_MAP[code[5:0]];
		end
		return c;
	endfunction

	function automatic logic [7:0] nav_code(input logic [6:0] code);
		logic [7:0] c;
		unique case (code)
			SC_UP:    c = NAV_CODE_BASE + 8'd0;
			SC_DOWN:  c = NAV_CODE_BASE + 8'd1;
			SC_LEFT:  c = NAV_CODE_BASE + 8'd2;
			SC_RIGHT: c = NAV_CODE_BASE + 8'd3;
			SC_PGUP:  c = NAV_CODE_BASE + 8'd4;
			SC_PGDN:  c = NAV_CODE_BASE + 8'd5;
			SC_HOME:  c = NAV_CODE_BASE + 8'd6;
			SC_END:   c = NAV_CODE_BASE + 8'd7;
			default:  c = 8'd0;
		endcase
		return c;
	endfunction

endpackage

@@ hdl/stc_req_if.sv @@
`timescale 1ns / 1ps
interface stc_req_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] scancode;

	modport source (output valid, output action, output scancode, input ready);
	modport sink (input valid, input action, input scancode, output ready);
endinterface

@@ hdl/stc_rsp_if.sv @@
`timescale 1ns / 1ps
interface stc_rsp_if;
	logic       valid;
	logic       ready;
	logic       read_valid;
	logic [7:0] read_char;
	logic       dropped;
	logic       has_char;

	modport source (output valid, output read_valid, output read_char, output dropped,
		output has_char, input ready);
	modport sink (input valid, input read_valid, input read_char, input dropped,
		input has_char, output ready);
endinterface

@@ hdl/stc_decode.sv @@
`timescale 1ns / 1ps
module stc_decode (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic [7:0] scancode,
	output logic [7:0] char_out
);
	import stc_pkg::*;

	logic shift_q;
	logic ctrl_q;
	logic prefix_q;
	logic shift_d;
	logic ctrl_d;
	logic prefix_d;
	logic [7:0] mapped;
	logic [6:0] code;

	assign code = scancode[6:0];

	always_comb begin
		shift_d  = shift_q;
		ctrl_d   = ctrl_q;
		prefix_d = prefix_q;
		char_out = 8'd0;
		mapped   = map_char(code, shift_q);
		priority if (scancode == SC_PREFIX) begin
			prefix_d = 1'b1;
		end else if (scancode[7]) begin
			// break code: release modifiers, drop any pending prefix
			if (code == SC_LSHIFT || code == SC_RSHIFT) shift_d = 1'b0;
			if (code == SC_CTRL) ctrl_d = 1'b0;
			prefix_d = 1'b0;
		end else if (code == SC_LSHIFT || code == SC_RSHIFT) begin
			shift_d = 1'b1;
		end else if (code == SC_CTRL) begin
			ctrl_d = 1'b1;
		end else if (prefix_q) begin
			prefix_d = 1'b0;
			char_out = nav_code(code);
		end else begin
			char_out = mapped;
			if (ctrl_q) begin
				if (mapped >= "a" && mapped <= "z") char_out = mapped - 8'd96;
				else if (mapped >= "A" && mapped <= "Z") char_out = mapped - 8'd64;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q  <= 1'b0;
			ctrl_q   <= 1'b0;
			prefix_q <= 1'b0;
		end else if (en) begin
			shift_q  <= shift_d;
			ctrl_q   <= ctrl_d;
			prefix_q <= prefix_d;
		end
	end

endmodule

@@ hdl/scancode_to_ascii_fifo.sv @@
`timescale 1ns / 1ps
// Set-1 scancode decoder feeding a character ring FIFO of FIFO_DEPTH entries
// (FIFO_DEPTH-1 usable). Each req item carries either a scancode byte
// (action 0) or a read request (action 1); each produces exactly one rsp item.
// One item is taken per clock unless the output stalls; the rsp goes through
// stage 1 (synchronous read of the character memory) and the output register.
// Reads of an empty FIFO return read_valid 0 and char 0; characters decoded
// while the FIFO is full are discarded with dropped set.
module scancode_to_ascii_fifo #(
	parameter int FIFO_DEPTH = stc_pkg::FIFO_DEPTH_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	stc_req_if.sink   req,
	stc_rsp_if.source rsp
);
	import stc_pkg::*;

	localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

	logic [7:0] mem [FIFO_DEPTH];

	logic [PTR_W-1:0] wr_q, rd_q, wr_d, rd_d, wr_inc, rd_inc;
	logic [7:0] dec_char;
	logic acc, push, do_push, pop, drop;

	logic       vld_s1, rvalid_s1, drop_s1, has_s1;
	logic [7:0] rdata_s1;
	logic       o_valid_q, o_rvalid_q, o_drop_q, o_has_q;
	logic [7:0] o_char_q;
	logic       adv_s1;

	assign adv_s1    = vld_s1 && (!o_valid_q || rsp.ready);
	assign req.ready = !vld_s1 || adv_s1;
	assign acc       = req.valid && req.ready;

	stc_decode u_dec (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (acc && !req.action),
		.scancode (req.scancode),
		.char_out (dec_char)
	);

	assign wr_inc  = (wr_q == PTR_LAST) ? '0 : wr_q + 1'b1;
	assign rd_inc  = (rd_q == PTR_LAST) ? '0 : rd_q + 1'b1;
	assign push    = acc && !req.action && (dec_char != 8'd0);
	assign do_push = push && (wr_inc != rd_q);
	assign drop    = push && (wr_inc == rd_q);
	assign pop     = acc && req.action && (wr_q != rd_q);
	assign wr_d    = do_push ? wr_inc : wr_q;
	assign rd_d    = pop ? rd_inc : rd_q;

	// a pop never targets the slot being written, so no forwarding is needed
	always_ff @(posedge clk) begin
		if (do_push) mem[wr_q] <= dec_char;
		if (pop) rdata_s1 <= mem[rd_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q       <= '0;
			rd_q       <= '0;
			vld_s1     <= 1'b0;
			rvalid_s1  <= 1'b0;
			drop_s1    <= 1'b0;
			has_s1     <= 1'b0;
			o_valid_q  <= 1'b0;
			o_rvalid_q <= 1'b0;
			o_drop_q   <= 1'b0;
			o_has_q    <= 1'b0;
			o_char_q   <= 8'd0;
		end else begin
			wr_q <= wr_d;
			rd_q <= rd_d;
			if (acc) begin
				vld_s1    <= 1'b1;
				rvalid_s1 <= pop;
				drop_s1   <= drop;
				has_s1    <= (wr_d != rd_d);
			end else if (adv_s1) begin
				vld_s1 <= 1'b0;
			end
			if (adv_s1) begin
				o_valid_q  <= 1'b1;
				o_rvalid_q <= rvalid_s1;
				o_char_q   <= rvalid_s1 ? rdata_s1 : 8'd0;
				o_drop_q   <= drop_s1;
				o_has_q    <= has_s1;
			end else if (rsp.ready) begin
				o_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid      = o_valid_q;
	assign rsp.read_valid = o_rvalid_q;
	assign rsp.read_char  = o_char_q;
	assign rsp.dropped    = o_drop_q;
	assign rsp.has_char   = o_has_q;

endmodule

@@ bench/tb_scancode_to_ascii_fifo.sv @@
`timescale 1ns / 1ps
module tb_scancode_to_ascii_fifo;

	localparam int FIFO_DEPTH  = stc_pkg::FIFO_DEPTH_DEF;
	localparam int PTR_BITS    = $clog2(FIFO_DEPTH);
	localparam int CYCLE_LIMIT = 200000;
	localparam int ITEM_TARGET = 750;
	localparam int DRAIN_WAIT  = 2000;
	localparam int TAIL_CYCLES = 10;

	localparam logic [7:0] KEY_PREFIX = 8'hE0;
	localparam logic [6:0] KEY_LSHIFT = 7'h2A;
	localparam logic [6:0] KEY_RSHIFT = 7'h36;
	localparam logic [6:0] KEY_CTRL   = 7'h1D;
	localparam logic [6:0] CODE_UP    = 7'h48;
	localparam logic [6:0] CODE_DOWN  = 7'h50;
	localparam logic [6:0] CODE_LEFT  = 7'h4B;
	localparam logic [6:0] CODE_RIGHT = 7'h4D;
	localparam logic [6:0] CODE_PGUP  = 7'h49;
	localparam logic [6:0] CODE_PGDN  = 7'h51;
	localparam logic [6:0] CODE_HOME  = 7'h47;
	localparam logic [6:0] CODE_END   = 7'h4F;
	localparam logic [7:0] NAV_BASE   = 8'd128;

	localparam logic [6:0] NAV_KEYS [8] = '{CODE_UP, CODE_DOWN, CODE_LEFT, CODE_RIGHT,
		CODE_PGUP, CODE_PGDN, CODE_HOME, CODE_END};

	localparam int MAP_ENTRIES = 59;

	localparam logic [7:0] LOWER_MAP [MAP_ENTRIES] = '{
		8'd0,  8'd27, "1",  "2",  "3",  "4",  "5",  "6",  "7",  "8",  "9",  "0",
		"-",   "=",   8'd8, 8'd9, "q",  "w",  "e",  "r",  "t",  "y",  "u",  "i",
		"o",   "p",   "[",  "]",  8'd10, 8'd0, "a", "s",  "d",  "f",  "g",  "h",
		"j",   "k",   "l",  ";",  8'd39, 8'd96, 8'd0, 8'd92, "z", "x", "c", "v",
		"b",   "n",   "m",  ",",  ".",  "/",  8'd0, "*",  8'd0, " ",  8'd0
	};

	localparam logic [7:0] UPPER_MAP [MAP_ENTRIES] = '{
		8'd0,  8'd27, "!",  "@",  "#",  "$",  "%",  "^",  "&",  "*",  "(",  ")",
		"_",   "+",   8'd8, 8'd9, "Q",  "W",  "E",  "R",  "T",  "Y",  "U",  "I",
		"O",   "P",   "{",  "}",  8'd10, 8'd0, "A", "S",  "D",  "F",  "G",  "H",
		"J",   "K",   "L",  ":",  8'd34, 8'd126, 8'd0, 8'd124, "Z", "X", "C", "V",
		"B",   "N",   "M",  "<",  ">",  "?",  8'd0, "*",  8'd0, " ",  8'd0
	};

	typedef enum logic {
		ACT_KEY  = 1'b0,
		ACT_READ = 1'b1
	} key_action_t;

	typedef struct {
		key_action_t action;
		logic [7:0]  scancode;
	} key_item_t;

	typedef struct packed {
		logic       read_valid;
		logic [7:0] read_char;
		logic       dropped;
		logic       has_char;
	} key_result_t;

	logic clk;
	logic arst_n;

	stc_req_if req ();
	stc_rsp_if rsp ();

	scancode_to_ascii_fifo #(
		.FIFO_DEPTH(FIFO_DEPTH)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req.sink),
		.rsp   (rsp.source)
	);

	key_item_t   pending_keys [$];
	key_result_t result_expect [$];

	logic [7:0] char_ring [FIFO_DEPTH];
	int         wr_ptr = 0;
	int         rd_ptr = 0;
	logic       shift_on = 1'b0;
	logic       ctrl_on = 1'b0;
	logic       e0_seen = 1'b0;

	int error_count = 0;
	int cycle_count;
	int burst_left;
	int gap_left;

	// Decode one item against the shadow keyboard state and ring.
	function automatic key_result_t decode_and_queue(input key_item_t it);
		key_result_t r;
		logic [7:0]  c;
		logic [6:0]  low;
		int          nxt;
		r   = '0;
		c   = 8'd0;
		low = it.scancode[6:0];
		if (it.action == ACT_READ) begin
			if (wr_ptr != rd_ptr) begin
				r.read_valid = 1'b1;
				r.read_char  = char_ring[PTR_BITS'(rd_ptr)];
				rd_ptr       = (rd_ptr + 1) % FIFO_DEPTH;
			end
		end else begin
			if (it.scancode == KEY_PREFIX) begin
				e0_seen = 1'b1;
			end else if (it.scancode[7]) begin
				if (low == KEY_LSHIFT || low == KEY_RSHIFT) shift_on = 1'b0;
				if (low == KEY_CTRL) ctrl_on = 1'b0;
				e0_seen = 1'b0;
			end else if (low == KEY_LSHIFT || low == KEY_RSHIFT) begin
				shift_on = 1'b1;
			end else if (low == KEY_CTRL) begin
				ctrl_on = 1'b1;
			end else if (e0_seen) begin
				e0_seen = 1'b0;
				case (low)
					CODE_UP:    c = NAV_BASE + 8'd0;
					CODE_DOWN:  c = NAV_BASE + 8'd1;
					CODE_LEFT:  c = NAV_BASE + 8'd2;
					CODE_RIGHT: c = NAV_BASE + 8'd3;
					CODE_PGUP:  c = NAV_BASE + 8'd4;
					CODE_PGDN:  c = NAV_BASE + 8'd5;
					CODE_HOME:  c = NAV_BASE + 8'd6;
					CODE_END:   c = NAV_BASE + 8'd7;
					default:    c = 8'd0;
				endcase
			end else begin
				if (int'(low) < MAP_ENTRIES) begin
					c = shift_on ? UPPER_MAP[low[5:0]] : LOWER_MAP[low[5:0]];
				end
				if (ctrl_on) begin
					if (c >= "a" && c <= "z") c = c - "a" + 8'd1;
					else if (c >= "A" && c <= "Z") c = c - "A" + 8'd1;
				end
			end
			if (c != 8'd0) begin
				nxt = (wr_ptr + 1) % FIFO_DEPTH;
				if (nxt != rd_ptr) begin
					char_ring[PTR_BITS'(wr_ptr)] = c;
					wr_ptr                       = nxt;
				end else begin
					r.dropped = 1'b1;
				end
			end
		end
		r.has_char = (wr_ptr != rd_ptr);
		return r;
	endfunction

	task automatic add_key(input logic [7:0] code);
		key_item_t it;
		it.action   = ACT_KEY;
		it.scancode = code;
		pending_keys.push_back(it);
	endtask

	task automatic add_read();
		key_item_t it;
		it.action   = ACT_READ;
		it.scancode = 8'($urandom);
		pending_keys.push_back(it);
	endtask

	// One keystroke pattern with random content, sometimes followed by a read.
	task automatic add_stroke(input int read_odds);
		int         kind;
		int         n;
		logic [6:0] code;
		logic [6:0] modkey;
		kind = $urandom_range(0, 15);
		case (kind)
			0, 1, 2, 3, 4, 5: begin
				code = 7'($urandom_range(1, MAP_ENTRIES - 1));
				add_key({1'b0, code});
				if ($urandom_range(0, 3) != 0) add_key({1'b1, code});
			end
			6, 7: begin
				modkey = $urandom_range(0, 1) ? KEY_LSHIFT : KEY_RSHIFT;
				add_key({1'b0, modkey});
				n = $urandom_range(1, 4);
				repeat (n) add_key({1'b0, 7'($urandom_range(1, MAP_ENTRIES - 1))});
				if ($urandom_range(0, 4) != 0) add_key({1'b1, modkey});
			end
			8: begin
				add_key({1'b0, KEY_CTRL});
				if ($urandom_range(0, 2) == 0) add_key({1'b0, KEY_LSHIFT});
				n = $urandom_range(1, 3);
				repeat (n) add_key({1'b0, 7'($urandom_range(1, MAP_ENTRIES - 1))});
				add_key({1'b1, KEY_LSHIFT});
				if ($urandom_range(0, 4) != 0) add_key({1'b1, KEY_CTRL});
			end
			9, 10: begin
				code = NAV_KEYS[3'($urandom_range(0, 7))];
				add_key(KEY_PREFIX);
				add_key({1'b0, code});
				add_key(KEY_PREFIX);
				add_key({1'b1, code});
			end
			11: begin
				add_key(KEY_PREFIX);
				add_key(8'($urandom));
			end
			12: begin
				modkey = $urandom_range(0, 1) ? KEY_CTRL : KEY_RSHIFT;
				add_key(KEY_PREFIX);
				add_key({1'b0, modkey});
				add_key({1'b0, NAV_KEYS[3'($urandom_range(0, 7))]});
			end
			13: add_key(8'($urandom));
			14: add_key({1'b0, 7'($urandom_range(MAP_ENTRIES, 127))});
			default: begin
				n = $urandom_range(1, 5);
				repeat (n) add_read();
			end
		endcase
		if ($urandom_range(0, 99) < read_odds) add_read();
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cycle_count <= 0;
		end else begin
			cycle_count <= cycle_count + 1;
			if (cycle_count >= CYCLE_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// Sender: bursts of random length separated by random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid    <= 1'b0;
			req.action   <= 1'b0;
			req.scancode <= 8'd0;
			burst_left   <= 0;
			gap_left     <= 0;
		end else begin
			if (req.valid && req.ready) begin
				key_item_t acc;
				acc.action   = key_action_t'(req.action);
				acc.scancode = req.scancode;
				result_expect.push_back(decode_and_queue(acc));
			end
			if (!req.valid || req.ready) begin
				if (gap_left > 0) begin
					gap_left  <= gap_left - 1;
					req.valid <= 1'b0;
				end else if (pending_keys.size() > 0) begin
					key_item_t nxt_item;
					nxt_item = pending_keys.pop_front();
					req.valid    <= 1'b1;
					req.action   <= nxt_item.action;
					req.scancode <= nxt_item.scancode;
					if (burst_left > 0) begin
						burst_left <= burst_left - 1;
					end else if ($urandom_range(0, 5) == 0) begin
						// long stretch with no gaps
						burst_left <= $urandom_range(80, 200);
						gap_left   <= 0;
					end else begin
						burst_left <= $urandom_range(1, 40);
						gap_left   <= $urandom_range(0, 6);
					end
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: the stall pattern is chosen by cycle_count[8:7].
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (result_expect.size() == 0) begin
					$error("unexpected result: read_valid %0d read_char %0d dropped %0d",
						rsp.read_valid, rsp.read_char, rsp.dropped);
					error_count++;
				end else begin
					key_result_t want;
					want = result_expect.pop_front();
					if (rsp.read_valid !== want.read_valid) begin
						$error("read_valid: expected %0d, got %0d", want.read_valid, rsp.read_valid);
						error_count++;
					end
					if (rsp.read_char !== want.read_char) begin
						$error("read_char: expected %0d, got %0d", want.read_char, rsp.read_char);
						error_count++;
					end
					if (rsp.dropped !== want.dropped) begin
						$error("dropped: expected %0d, got %0d", want.dropped, rsp.dropped);
						error_count++;
					end
					if (rsp.has_char !== want.has_char) begin
						$error("has_char: expected %0d, got %0d", want.has_char, rsp.has_char);
						error_count++;
					end
				end
			end
			case (cycle_count[8:7])
				2'd0: rsp.ready <= 1'b1;
				2'd1: rsp.ready <= ($urandom_range(0, 3) != 0);
				2'd2: rsp.ready <= 1'($urandom_range(0, 1));
				default: rsp.ready <= (cycle_count[3:0] < 4'd11);
			endcase
		end
	end

	initial begin
		int waited;
		arst_n = 1'b0;

		// directed: empty read, extremes, modifiers, ctrl folding, prefix cases
		add_read();
		add_key(8'h00);
		add_key(8'hFF);
		add_key(8'h7F);
		add_key(8'h1E);
		add_key({1'b0, KEY_LSHIFT});
		add_key(8'h03);
		add_key({1'b1, KEY_LSHIFT});
		add_key({1'b0, KEY_RSHIFT});
		add_key({1'b0, KEY_CTRL});
		add_key(8'h1E);
		add_key({1'b1, KEY_RSHIFT});
		add_key(8'h2C);
		add_key({1'b1, KEY_CTRL});
		add_key(KEY_PREFIX);
		add_key({1'b0, CODE_UP});
		add_key(KEY_PREFIX);
		add_key({1'b0, KEY_LSHIFT});
		add_key({1'b0, CODE_END});
		add_key(KEY_PREFIX);
		add_key(8'h1E);
		add_key(KEY_PREFIX);
		add_key({1'b1, CODE_UP});
		add_key(8'h39);
		add_key({1'b1, KEY_LSHIFT});
		repeat (3) add_read();

		while (pending_keys.size() < 230) add_stroke(35);
		// release all modifiers, then type letters until the ring overflows
		add_key({1'b1, KEY_LSHIFT});
		add_key({1'b1, KEY_RSHIFT});
		add_key({1'b1, KEY_CTRL});
		repeat (270) begin
			if ($urandom_range(0, 1)) add_key(8'($urandom_range(8'h10, 8'h19)));
			else add_key(8'($urandom_range(8'h1E, 8'h26)));
		end
		while (pending_keys.size() < 610) add_stroke(40);
		repeat (100) add_read();
		while (pending_keys.size() < ITEM_TARGET) add_stroke(50);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_keys.size() != 0 || req.valid) @(negedge clk);
		waited = 0;
		while (result_expect.size() != 0 && waited < DRAIN_WAIT) begin
			@(negedge clk);
			waited++;
		end
		repeat (TAIL_CYCLES) @(negedge clk);
		if (result_expect.size() != 0) begin
			$error("%0d expected results never arrived", result_expect.size());
		end

		if (error_count == 0 && result_expect.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
